/* src/tmhq_pkg.sv */
// ----------------------------------------------------------------------------
// tmhq_pkg
// Shared types, codes and sizes of the ternary max-heap queue.
// ----------------------------------------------------------------------------
package tmhq_pkg;

    localparam int DEF_CAPACITY = 32;
    localparam int DEF_KEY_BITS = 16;
    localparam int PRIO_W       = 16;
    localparam int PAY_W        = 8;
    localparam int KIND_W       = 3;
    localparam int STATUS_W     = 2;
    localparam int OCC_W        = 6;

    // command codes
    localparam logic [KIND_W-1:0] K_APPEND  = 3'd0;
    localparam logic [KIND_W-1:0] K_HEAPIFY = 3'd1;
    localparam logic [KIND_W-1:0] K_INSERT  = 3'd2;
    localparam logic [KIND_W-1:0] K_DELMAX  = 3'd3;
    localparam logic [KIND_W-1:0] K_PEEK    = 3'd4;
    localparam logic [KIND_W-1:0] K_DUMP    = 3'd5;
    localparam logic [KIND_W-1:0] K_SORT    = 3'd6;
    localparam logic [KIND_W-1:0] K_RSVD    = 3'd7;   // unused, answered with ok

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic signed [PRIO_W-1:0] priority_req;
        logic [PAY_W-1:0] payload;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic signed [PRIO_W-1:0] out_priority;
        logic [PAY_W-1:0] out_payload;
        logic has_entry;
        logic last;
        logic [OCC_W-1:0] occupancy;
    } t_rsp;

endpackage

/* src/tmhq_if.sv */
// ----------------------------------------------------------------------------
// tmhq_req_if / tmhq_rsp_if
// Valid/ready channels for commands and results.
// ----------------------------------------------------------------------------
interface tmhq_req_if import tmhq_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tmhq_rsp_if import tmhq_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* src/ternary_max_heap_queue_top.sv */
// ----------------------------------------------------------------------------
// ternary_max_heap_queue_top
// Ternary max-heap of (key, byte) entries held in one synchronous memory.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one command (kind, priority_req, payload). o_rsp returns
//   one or more results; the final result of a command has last set.
//   One command is worked on at a time; i_req.ready is high only when the
//   sequencer is idle and the result register is empty.
//   The heap lives in one memory with a registered read port. A sift-down
//   level requests the three children in turn, compares each as it arrives,
//   then decides and writes back. Delete max sinks the last entry from the
//   root; heapify and insert sift down every parent from the last one up;
//   sort heapifies, parks each root at the end of the shrinking heap, then
//   dumps the entries.
//   A stalled receiver holds the result register; the sequencer waits on
//   its next result and nothing is dropped. Reset empties the heap at once;
//   memory contents need no clearing since only entries below the count
//   are used, and the dump of a sort reads back only the entries it parked.
// ----------------------------------------------------------------------------
module ternary_max_heap_queue_top import tmhq_pkg::*; #(
    parameter int CAPACITY = DEF_CAPACITY,
    parameter int KEY_BITS = DEF_KEY_BITS
) (
    input logic         i_clk,
    input logic         i_rst_n,
    tmhq_req_if.sink    i_req,
    tmhq_rsp_if.source  o_rsp
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = CW + 2;   // room for 3*i+3 up to the capacity

    typedef struct packed {
        logic signed [KEY_BITS-1:0] key;
        logic [PAY_W-1:0] val;
    } t_ent;

    typedef enum logic [4:0] {
        S_IDLE, S_APPEND, S_HP_NEXT, S_HP_LOAD, S_SD_C0, S_SD_C1, S_SD_C2,
        S_SD_C3, S_DEL_ROOT, S_DEL_LAST, S_PEEK, S_SORT_NEXT, S_SORT_LAST,
        S_SORT_ROOT, S_DUMP_RD, S_DUMP_OUT, S_RESP
    } t_state;

    // heap memory
    t_ent           mem [CAPACITY];
    logic           mem_we;
    logic [AW-1:0]  mem_wa;
    t_ent           mem_wd;
    logic [AW-1:0]  mem_ra;
    t_ent           r_rd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd <= mem[mem_ra];
    end

    t_state          r_state, n_state;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [KIND_W-1:0] r_kind, n_kind;
    logic [IW-1:0]   r_j, n_j;         // sift-down node
    logic [CW-1:0]   r_hp, n_hp;       // heapify counter (next parent + 1)
    logic [IW-1:0]   r_best, n_best;
    logic [CW-1:0]   r_i, n_i;         // dump index
    logic [CW-1:0]   r_n, n_n;         // entries to emit in the dump pass
    t_ent            r_ej, n_ej;       // entry sinking from node j
    t_ent            r_eb, n_eb;       // best entry so far
    t_ent            r_tmp, n_tmp;
    logic            r_heap, n_heap;   // sift-down called from heapify
    logic            r_ov, n_ov;
    t_rsp            r_out, n_out;

    // floor(x / 3) by reciprocal multiplication, exact for x below 2^16
    function automatic logic [CW-1:0] div3(input logic [CW-1:0] x);
        logic [31:0] p;
        p = 32'(x) * 32'd43691;
        return CW'(p[31:17]);
    endfunction

    // one past the last parent of a heap of n entries
    function automatic logic [CW-1:0] hp_start(input logic [CW-1:0] n);
        logic [CW-1:0] s;
        if (n < CW'(2)) s = '0;
        else s = div3(n - CW'(2)) + CW'(1);
        return s;
    endfunction

    function automatic t_rsp mk(input logic [STATUS_W-1:0] st, input logic he,
                                input t_ent e, input logic lst,
                                input logic [CW-1:0] occ);
        t_rsp r;
        r.status       = st;
        r.out_priority = he ? PRIO_W'(e.key) : '0;
        r.out_payload  = he ? e.val : '0;
        r.has_entry    = he;
        r.last         = lst;
        r.occupancy    = OCC_W'(occ);
        return r;
    endfunction

    // child that arrives from memory in this cycle, and whether it wins
    logic [IW-1:0] c_left;
    logic [IW-1:0] c_cur;
    logic          take;
    always_comb begin
        c_left = IW'({r_j, 1'b0}) + r_j + IW'(1);
        case (r_state)
            S_SD_C2: c_cur = c_left + IW'(1);
            S_SD_C3: c_cur = c_left + IW'(2);
            default: c_cur = c_left;
        endcase
        take = (c_cur < IW'(r_cnt)) && (r_rd.key > r_eb.key);
    end

    // where a finished sift-down returns to
    t_state sd_done;
    assign sd_done = r_heap ? S_HP_NEXT : ((r_kind == K_SORT) ? S_SORT_NEXT : S_RESP);

    logic dump_last;
    assign dump_last = (r_i + CW'(1)) == r_n;

    assign i_req.ready = (r_state == S_IDLE) && !r_ov;
    assign o_rsp.valid = r_ov;
    assign o_rsp.data  = r_out;

    logic out_free;
    assign out_free = !r_ov || o_rsp.ready;

    always_comb begin
        n_state = r_state; n_cnt = r_cnt; n_kind = r_kind; n_j = r_j;
        n_hp = r_hp; n_best = r_best; n_i = r_i; n_n = r_n; n_ej = r_ej;
        n_eb = r_eb; n_tmp = r_tmp; n_heap = r_heap;
        n_ov = r_ov && !o_rsp.ready; n_out = r_out;
        mem_we = 1'b0; mem_wa = '0; mem_wd = r_ej; mem_ra = '0;

        case (r_state)
            S_IDLE: begin
                // root is read by default, ready for peek and delete max
                if (i_req.valid && i_req.ready) begin
                    n_kind = i_req.data.kind;
                    n_tmp.key = KEY_BITS'(i_req.data.priority_req);
                    n_tmp.val = i_req.data.payload;
                    n_heap = 1'b0;
                    case (i_req.data.kind)
                        K_APPEND, K_INSERT: begin
                            if (r_cnt >= CW'(CAPACITY)) begin
                                n_out = mk(ST_FULL, 1'b0, '0, 1'b1, r_cnt);
                                n_ov = 1'b1;
                            end else begin
                                n_state = S_APPEND;
                            end
                        end
                        K_HEAPIFY: begin
                            n_hp = hp_start(r_cnt);
                            n_heap = 1'b1;
                            n_state = S_HP_NEXT;
                        end
                        K_DELMAX, K_PEEK, K_DUMP, K_SORT: begin
                            if (r_cnt == '0) begin
                                n_out = mk(ST_EMPTY, 1'b0, '0, 1'b1, r_cnt);
                                n_ov = 1'b1;
                            end else if (i_req.data.kind == K_DUMP) begin
                                n_i = '0;
                                n_n = r_cnt;
                                n_state = S_DUMP_RD;
                            end else if (i_req.data.kind == K_SORT) begin
                                n_hp = hp_start(r_cnt);
                                n_heap = 1'b1;
                                n_state = S_HP_NEXT;
                            end else begin
                                mem_ra = '0;
                                n_state = (i_req.data.kind == K_PEEK) ? S_PEEK : S_DEL_ROOT;
                            end
                        end
                        default: begin
                            n_out = mk(ST_OK, 1'b0, '0, 1'b1, r_cnt);
                            n_ov = 1'b1;
                        end
                    endcase
                end
            end
            S_APPEND: begin
                mem_we = 1'b1; mem_wa = AW'(r_cnt); mem_wd = r_tmp;
                n_cnt = r_cnt + CW'(1);
                if (r_kind == K_INSERT) begin
                    n_hp = hp_start(r_cnt + CW'(1));
                    n_heap = 1'b1;
                    n_state = S_HP_NEXT;
                end else n_state = S_RESP;
            end
            S_HP_NEXT: begin
                // next parent of the heapify pass, or finish
                if (r_hp == '0) begin
                    n_heap = 1'b0;
                    if (r_kind == K_SORT) begin
                        n_n = r_cnt;
                        n_state = S_SORT_NEXT;
                    end else n_state = S_RESP;
                end else begin
                    n_hp = r_hp - CW'(1);
                    n_j = IW'(r_hp - CW'(1));
                    mem_ra = AW'(r_hp - CW'(1));
                    n_state = S_HP_LOAD;
                end
            end
            S_HP_LOAD: begin
                n_ej = r_rd;
                n_state = S_SD_C0;
            end
            S_SD_C0: begin
                // request left child, or settle the entry at a leaf
                n_best = r_j;
                n_eb = r_ej;
                if (c_left < IW'(r_cnt)) begin
                    mem_ra = AW'(c_left);
                    n_state = S_SD_C1;
                end else begin
                    mem_we = 1'b1; mem_wa = AW'(r_j); mem_wd = r_ej;
                    n_state = sd_done;
                end
            end
            S_SD_C1, S_SD_C2: begin
                // compare child that just arrived, request the next one
                if (take) begin
                    n_eb = r_rd; n_best = c_cur;
                end
                mem_ra = AW'(c_cur + IW'(1));
                n_state = (r_state == S_SD_C1) ? S_SD_C2 : S_SD_C3;
            end
            S_SD_C3: begin
                // last child decides: move the winner up or settle here
                mem_we = 1'b1; mem_wa = AW'(r_j);
                if (take) begin
                    mem_wd = r_rd;
                    n_j = c_cur;
                    n_state = S_SD_C0;
                end else if (r_best != r_j) begin
                    mem_wd = r_eb;
                    n_j = r_best;
                    n_state = S_SD_C0;
                end else begin
                    mem_wd = r_ej;
                    n_state = sd_done;
                end
            end
            S_DEL_ROOT: begin
                // capture root, read last entry
                n_tmp = r_rd;
                mem_ra = AW'(r_cnt - CW'(1));
                n_state = S_DEL_LAST;
            end
            S_DEL_LAST: begin
                // sink the last entry from the root
                n_ej = r_rd;
                n_cnt = r_cnt - CW'(1);
                n_j = '0;
                n_state = S_SD_C0;
            end
            S_PEEK: begin
                n_tmp = r_rd;
                n_state = S_RESP;
            end
            S_SORT_NEXT: begin
                // read the end of the shrinking heap, or start the dump
                if (r_cnt == '0) begin
                    n_i = '0;
                    n_state = S_DUMP_RD;
                end else begin
                    mem_ra = AW'(r_cnt - CW'(1));
                    n_state = S_SORT_LAST;
                end
            end
            S_SORT_LAST: begin
                n_ej = r_rd;
                mem_ra = '0;
                n_state = S_SORT_ROOT;
            end
            S_SORT_ROOT: begin
                // park the root at the end, sink the old end from the root
                mem_we = 1'b1; mem_wa = AW'(r_cnt - CW'(1)); mem_wd = r_rd;
                n_cnt = r_cnt - CW'(1);
                n_j = '0;
                n_state = S_SD_C0;
            end
            S_DUMP_RD: begin
                mem_ra = AW'(r_i);
                n_state = S_DUMP_OUT;
            end
            S_DUMP_OUT: begin
                // hold the read address while the receiver stalls
                mem_ra = AW'(r_i);
                if (out_free) begin
                    n_out = mk(ST_OK, 1'b1, r_rd, dump_last, r_cnt);
                    n_ov = 1'b1;
                    n_i = r_i + CW'(1);
                    n_state = dump_last ? S_IDLE : S_DUMP_RD;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_out = mk(ST_OK, (r_kind == K_DELMAX) || (r_kind == K_PEEK),
                               r_tmp, 1'b1, r_cnt);
                    n_ov = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
            r_heap  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ov    <= n_ov;
            r_heap  <= n_heap;
        end
        r_kind <= n_kind; r_j <= n_j; r_hp <= n_hp; r_best <= n_best;
        r_i <= n_i; r_n <= n_n; r_ej <= n_ej; r_eb <= n_eb; r_tmp <= n_tmp;
        r_out <= n_out;
    end

endmodule
